// ===== hw/rtl/gcd_pkg.sv =====
// gcd_pkg: shared constants for the grid cross dilation block
// register map, action codes, reset values and default sizes
// no dependencies
package gcd_pkg;

    // default sizes of the line buffers and the row counter
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    // configuration register format
    localparam int CFG_W        = 11;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [CFG_W-1:0] GRID_COLUMNS_RST = 11'd10;
    localparam logic [CFG_W-1:0] GRID_ROWS_RST    = 11'd10;

    // register index, taken from paddr[2]
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    // input item action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

endpackage

// ===== hw/rtl/gcd_if.sv =====
// gcd_if: valid/ready stream interfaces for cell items and result items
// no dependencies
interface gcd_in_if;
    logic valid;
    logic ready;
    logic action;
    logic cell_burning;

    modport source (output valid, output action, output cell_burning, input ready);
    modport sink   (input valid, input action, input cell_burning, output ready);
endinterface

interface gcd_out_if;
    logic valid;
    logic ready;
    logic next_burning;
    logic frame_last;

    modport source (output valid, output next_burning, output frame_last, input ready);
    modport sink   (input valid, input next_burning, input frame_last, output ready);
endinterface

// ===== hw/rtl/grid_cross_dilation.sv =====
// grid_cross_dilation: one cross-shaped spread step over a raster stream of binary cells
// depends on gcd_pkg and the stream interfaces in gcd_if
//
// channel        | dir | transfer condition     | payload
// ---------------+-----+------------------------+------------------------------
// i_cell_stream  | in  | valid && ready         | action, cell_burning
// o_cell_stream  | out | valid && ready         | next_burning, frame_last
// apb            | in  | psel && penable && pwr | paddr, pwdata (prdata on read)
//
// one item per cycle: every stored pixel does a single read-modify-write of the two line
// memories, a flush only reads, and the reads for the next column issue in the same cycle
// a result sits in the output register in the cycle after its input transfer
// after reset a clearing pass over all MAX_COLUMNS entries zeroes both line memories;
// input ready stays low during it, configuration writes are taken as ever
// a stalled output holds its register and input ready drops until it is taken
module grid_cross_dilation #(
    parameter int MAX_COLUMNS = gcd_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gcd_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gcd_in_if.sink                        i_cell_stream,
    gcd_out_if.source                     o_cell_stream,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    // column index, row index and flush counter widths
    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int PW   = $clog2(MAX_COLUMNS + 1);
    // widths for the clamped sizes, wide enough for the register and the maximum
    localparam int CFWC = ($clog2(MAX_COLUMNS + 1) > gcd_pkg::CFG_W) ?
                          $clog2(MAX_COLUMNS + 1) : gcd_pkg::CFG_W;
    localparam int CFWR = ($clog2(MAX_ROWS + 1) > gcd_pkg::CFG_W) ?
                          $clog2(MAX_ROWS + 1) : gcd_pkg::CFG_W;

    // state codes
    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // configuration registers
    logic [gcd_pkg::CFG_W-1:0] r_grid_columns;
    logic [gcd_pkg::CFG_W-1:0] r_grid_rows;

    // control state
    logic          r_state, n_state;
    logic [CW-1:0] r_clr_idx, n_clr_idx;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] r_pending, n_pending;
    logic          r_left, n_left;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_out_burn, n_out_burn;
    logic r_out_last, n_out_last;

    // line memories: upper holds the row above the output row, middle the output row
    logic mem_upper  [MAX_COLUMNS];
    logic mem_middle [MAX_COLUMNS];

    // registered read data and write-through bypass for same-entry collisions
    logic r_mid_c_q, r_mid_r_q, r_up_c_q;
    logic r_mid_c_byp, r_mid_r_byp, r_up_c_byp;
    logic r_mid_wd, r_up_wd;

    // memory port signals
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic          mem_mid_wd, mem_up_wd;
    logic [CW-1:0] rd_addr_c, rd_addr_r;

    // window values for the current column
    logic cur_mid, cur_right, cur_up;

    logic in_fire, is_flush, flush_go, push_go;
    logic [CFWC-1:0] cols_eff, cols_ext;
    logic [CFWR-1:0] rows_eff, rows_ext;
    logic [CW:0]     col_inc;
    logic [RW:0]     row_inc;
    logic            last_col, last_row, row_nz, pend_last, left_use;
    logic            push_val, flush_val;
    logic            cfg_wr;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= gcd_pkg::GRID_COLUMNS_RST;
            r_grid_rows    <= gcd_pkg::GRID_ROWS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                gcd_pkg::REG_GRID_COLUMNS: r_grid_columns <= pwdata[gcd_pkg::CFG_W-1:0];
                gcd_pkg::REG_GRID_ROWS:    r_grid_rows    <= pwdata[gcd_pkg::CFG_W-1:0];
                default:                   r_grid_rows    <= r_grid_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            gcd_pkg::REG_GRID_COLUMNS: prdata = gcd_pkg::APB_DATA_W'(r_grid_columns);
            gcd_pkg::REG_GRID_ROWS:    prdata = gcd_pkg::APB_DATA_W'(r_grid_rows);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // sizes: zero acts as one, anything above the maximum as the maximum
    // ---------------------------------------------------------------
    assign cols_ext = CFWC'(r_grid_columns);
    assign rows_ext = CFWR'(r_grid_rows);

    always_comb begin
        priority if (cols_ext == '0)
            cols_eff = CFWC'(1);
        else if (cols_ext > CFWC'(MAX_COLUMNS))
            cols_eff = CFWC'(MAX_COLUMNS);
        else
            cols_eff = cols_ext;
        priority if (rows_ext == '0)
            rows_eff = CFWR'(1);
        else if (rows_ext > CFWR'(MAX_ROWS))
            rows_eff = CFWR'(MAX_ROWS);
        else
            rows_eff = rows_ext;
    end

    // ---------------------------------------------------------------
    // input handshake and item decode
    // ---------------------------------------------------------------
    // the output register frees up in the same cycle it is taken
    assign i_cell_stream.ready = (r_state == ST_RUN) && (!r_out_valid || o_cell_stream.ready);
    assign in_fire  = i_cell_stream.valid && i_cell_stream.ready;
    assign is_flush = (i_cell_stream.action == gcd_pkg::ACT_FLUSH);
    // a flush with nothing owed and a pixel during a drain are taken and dropped
    assign flush_go = in_fire && is_flush && (r_pending != '0);
    assign push_go  = in_fire && !is_flush && (r_pending == '0);

    // window from the registered reads, patched by last cycle's write
    assign cur_mid   = r_mid_c_byp ? r_mid_wd : r_mid_c_q;
    assign cur_right = r_mid_r_byp ? r_mid_wd : r_mid_r_q;
    assign cur_up    = r_up_c_byp  ? r_up_wd  : r_up_c_q;

    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign row_inc   = {1'b0, r_row} + 1'b1;
    assign last_col  = CFWC'(col_inc) >= cols_eff;
    assign last_row  = CFWR'(row_inc) >= rows_eff;
    assign row_nz    = (r_row != '0);
    assign pend_last = (r_pending == PW'(1));
    // no spreading across the left row end
    assign left_use  = (r_col != '0) && r_left;

    // pixel: right neighbor stops at the row end
    assign push_val  = cur_mid | cur_up | i_cell_stream.cell_burning | left_use |
                       (!last_col && cur_right);
    // flush: right neighbor exists while more than one cell is owed
    assign flush_val = cur_mid | cur_up | left_use | (!pend_last && cur_right);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_col       = r_col;
        n_row       = r_row;
        n_pending   = r_pending;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_cell_stream.ready;
        n_out_burn  = r_out_burn;
        n_out_last  = r_out_last;

        mem_we      = 1'b0;
        mem_waddr   = r_col;
        mem_mid_wd  = i_cell_stream.cell_burning;
        mem_up_wd   = row_nz && cur_mid;

        unique case (r_state)
            ST_CLEAR: begin
                // zero one entry of each line per cycle
                mem_we     = 1'b1;
                mem_waddr  = r_clr_idx;
                mem_mid_wd = 1'b0;
                mem_up_wd  = 1'b0;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == CW'(MAX_COLUMNS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (push_go) begin
                    // old middle moves up, the new cell lands in the middle line
                    mem_we = 1'b1;
                    n_left = cur_mid;
                    if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_row     = '0;
                            n_pending = PW'(cols_eff);
                        end else begin
                            n_row = row_inc[RW-1:0];
                        end
                    end else begin
                        n_col = col_inc[CW-1:0];
                    end
                    // the first row of a frame is only stored
                    if (row_nz) begin
                        n_out_valid = 1'b1;
                        n_out_burn  = push_val;
                        n_out_last  = 1'b0;
                    end
                end else if (flush_go) begin
                    n_left      = cur_mid;
                    n_pending   = r_pending - 1'b1;
                    n_col       = pend_last ? '0 : col_inc[CW-1:0];
                    n_out_valid = 1'b1;
                    n_out_burn  = flush_val;
                    n_out_last  = pend_last;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // read the column the next item will use and its right neighbor
    assign rd_addr_c = n_col;
    assign rd_addr_r = n_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pending   <= '0;
            r_left      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pending   <= n_pending;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_burn <= n_out_burn;
        r_out_last <= n_out_last;
    end

    // ---------------------------------------------------------------
    // line memories: one write, middle read at two addresses, upper at one
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_middle[mem_waddr] <= mem_mid_wd;
            mem_upper[mem_waddr]  <= mem_up_wd;
        end
        r_mid_c_q <= mem_middle[rd_addr_c];
        r_mid_r_q <= mem_middle[rd_addr_r];
        r_up_c_q  <= mem_upper[rd_addr_c];
    end

    // same-entry read and write in one cycle: take the written value
    always_ff @(posedge i_clk) begin
        r_mid_c_byp <= mem_we && (mem_waddr == rd_addr_c);
        r_mid_r_byp <= mem_we && (mem_waddr == rd_addr_r);
        r_up_c_byp  <= mem_we && (mem_waddr == rd_addr_c);
        r_mid_wd    <= mem_mid_wd;
        r_up_wd     <= mem_up_wd;
    end

    assign o_cell_stream.valid        = r_out_valid;
    assign o_cell_stream.next_burning = r_out_burn;
    assign o_cell_stream.frame_last   = r_out_last;

endmodule

// ===== hw/rtl/gcd_checker.sv =====
// gcd_checker: port-level checks for grid_cross_dilation, bound to the top level
// depends on gcd_pkg
module gcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_burn,
    input logic                           out_last,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [gcd_pkg::APB_ADDR_W-1:0] paddr,
    input logic [gcd_pkg::APB_DATA_W-1:0] pwdata,
    input logic [gcd_pkg::APB_DATA_W-1:0] prdata
);

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    // reset empties the output register
    assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // the line clearing pass holds off input after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !in_ready)
        else $error("input ready during line clearing");

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_burn) && $stable(out_last))
        else $error("stalled result changed");

    // a new result only follows an input transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without input transfer");

    // a written column count reads back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == gcd_pkg::REG_GRID_COLUMNS) ##1
        (paddr[2] == gcd_pkg::REG_GRID_COLUMNS && !cfg_wr)
        |-> prdata[gcd_pkg::CFG_W-1:0] == $past(pwdata[gcd_pkg::CFG_W-1:0]))
        else $error("column register read-back mismatch");

endmodule

bind grid_cross_dilation gcd_checker u_gcd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_cell_stream.valid),
    .in_ready  (i_cell_stream.ready),
    .out_valid (o_cell_stream.valid),
    .out_ready (o_cell_stream.ready),
    .out_burn  (o_cell_stream.next_burning),
    .out_last  (o_cell_stream.frame_last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
